// ===== rtl/core/gsd_pkg.sv =====
// ----------------------------------------------------------------------------
// gsd_pkg
// Types and constants shared by the glyph stroke decoder modules.
// ----------------------------------------------------------------------------
package gsd_pkg;

  localparam int CodeW  = 8;
  localparam int OrigW  = 10;
  localparam int PosW   = 12;
  localparam int SizeW  = 9;
  localparam int ScaleW = 4;
  localparam int ColorW = 16;
  localparam int CellW  = 6;

  localparam int InDataW  = 32;
  localparam int OutDataW = 64;

  localparam logic RegScale     = 1'b0;
  localparam logic RegDrawColor = 1'b1;

  localparam logic KindRect = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [ScaleW-1:0] ScaleReset = 4'd1;
  localparam logic [ColorW-1:0] ColorReset = 16'hFFFF;

  localparam int EndBit  = 7;
  localparam int LineBit = 6;
  localparam int VertBit = 6;
  localparam int MirrBit = 5;

  localparam logic [6:0] VertStep = 7'd8;
  localparam logic [6:0] HorzStep = 7'd1;

  typedef struct packed {
    logic             line_pending;
    logic [CellW-1:0] pending_cell;
    logic             glyph_halted;
  } gsd_state_t;

  typedef struct packed {
    logic              kind;
    logic [PosW-1:0]   rect_x;
    logic [PosW-1:0]   rect_y;
    logic [SizeW-1:0]  rect_w;
    logic [SizeW-1:0]  rect_h;
    logic [ColorW-1:0] color;
  } gsd_result_t;

endpackage

// ===== rtl/core/gsd_step.sv =====
// ----------------------------------------------------------------------------
// gsd_step
// Decodes one stroke byte against the pending state into an optional result.
// ----------------------------------------------------------------------------
module gsd_step (
  input  logic [gsd_pkg::CodeW-1:0]  code_byte,
  input  logic                       glyph_start,
  input  logic [gsd_pkg::OrigW-1:0]  origin_x,
  input  logic [gsd_pkg::OrigW-1:0]  origin_y,
  input  logic [gsd_pkg::ScaleW-1:0] scale,
  input  logic [gsd_pkg::ColorW-1:0] draw_color,
  input  gsd_pkg::gsd_state_t        state,
  output gsd_pkg::gsd_state_t        state_next,
  output logic                       emit,
  output gsd_pkg::gsd_result_t       result
);
  import gsd_pkg::*;

  gsd_state_t       st;
  logic             vert;
  logic             mirr;
  logic [5:0]       len;
  logic [5:0]       back;
  logic [6:0]       cell_idx;
  logic [2:0]       col;
  logic [3:0]       row;
  logic signed [7:0]  xc;
  logic signed [7:0]  yc;
  logic signed [12:0] xprod;
  logic signed [12:0] yprod;
  logic [12:0]        xsum;
  logic [12:0]        ysum;
  logic [9:0]         lens;
  logic [SizeW-1:0]   s_size;
  logic               is_line;

  assign vert = code_byte[VertBit];
  assign mirr = code_byte[MirrBit];
  assign len  = {1'b0, code_byte[4:0]} + 6'd1;
  assign back = mirr ? len : 6'd0;
  assign lens = {4'b0, len} * {6'b0, scale};
  assign s_size = {5'b0, scale};

  always_comb begin
    st = glyph_start ? '0 : state;
    is_line = st.line_pending;
    if (is_line) begin
      cell_idx = {1'b0, st.pending_cell} + (mirr ? (vert ? VertStep : HorzStep) : 7'd0);
    end else begin
      cell_idx = {1'b0, code_byte[5:0]};
    end
    col = cell_idx[2:0];
    row = cell_idx[6:3];
    xc = $signed({5'b0, col});
    yc = $signed({4'b0, row});
    if (is_line && vert) begin
      yc = $signed({4'b0, row}) - $signed({2'b0, back});
    end else if (is_line) begin
      xc = $signed({5'b0, col}) - $signed({2'b0, back});
    end
  end

  assign xprod = 13'(xc) * $signed({9'b0, scale});
  assign yprod = 13'(yc) * $signed({9'b0, scale});
  assign xsum  = {3'b0, origin_x} + xprod;
  assign ysum  = {3'b0, origin_y} + yprod;

  always_comb begin
    state_next    = st;
    emit          = 1'b0;
    result.kind   = KindRect;
    result.rect_x = xsum[PosW-1:0];
    result.rect_y = ysum[PosW-1:0];
    result.rect_w = s_size;
    result.rect_h = s_size;
    result.color  = draw_color;
    if (st.glyph_halted) begin
      emit = 1'b0;
    end else if (code_byte[EndBit]) begin
      state_next = '{line_pending: 1'b0, pending_cell: '0, glyph_halted: 1'b1};
      emit = 1'b1;
      result = '{kind: KindEnd, default: '0};
    end else if (st.line_pending) begin
      state_next.line_pending = 1'b0;
      state_next.pending_cell = '0;
      emit = 1'b1;
      if (vert) begin
        result.rect_h = lens[SizeW-1:0];
      end else begin
        result.rect_w = lens[SizeW-1:0];
      end
    end else if (code_byte[LineBit]) begin
      state_next.line_pending = 1'b1;
      state_next.pending_cell = code_byte[CellW-1:0];
    end else begin
      emit = 1'b1;
    end
  end

endmodule

// ===== rtl/core/gsd_result_reg.sv =====
// ----------------------------------------------------------------------------
// gsd_result_reg
// Result register on the master side: holds one item until it is taken.
// ----------------------------------------------------------------------------
module gsd_result_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  gsd_pkg::gsd_result_t         result,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gsd_pkg::OutDataW-1:0] m_tdata,   // rect_x, rect_y, rect_w, rect_h, color
  output logic                         m_tuser    // kind
);
  import gsd_pkg::*;

  gsd_result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= result;
    end
  end

  assign m_tdata = {6'b0, held.color, held.rect_h, held.rect_w, held.rect_y, held.rect_x};
  assign m_tuser = held.kind;

endmodule

// ===== rtl/core/glyph_stroke_decoder.sv =====
// ----------------------------------------------------------------------------
// glyph_stroke_decoder
// Turns a stroke-coded glyph byte stream into scaled fill rectangles.
// ----------------------------------------------------------------------------
// One byte is taken per clock unless the master side stalls. Each byte is
// captured in an input register, decoded against the pending line state in one
// pass of logic and, if it yields a rectangle or an end marker, loaded into the
// result register. While a result waits on the master side the input register
// takes at most one byte and then holds it. Line opening bytes and bytes after
// an end marker give no result. The user writes scale and draw_color through
// the cfg port only while no byte is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module glyph_stroke_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [gsd_pkg::InDataW-1:0]  s_tdata,   // code_byte, origin_x, origin_y
  input  logic                         s_tuser,   // glyph_start
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gsd_pkg::OutDataW-1:0] m_tdata,   // rect_x, rect_y, rect_w, rect_h, color
  output logic                         m_tuser,   // kind
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [gsd_pkg::ColorW-1:0]   cfg_data
);
  import gsd_pkg::*;

  logic              in_valid;
  logic [CodeW-1:0]  in_code;
  logic              in_start;
  logic [OrigW-1:0]  in_ox;
  logic [OrigW-1:0]  in_oy;
  logic [ScaleW-1:0] scale;
  logic [ColorW-1:0] draw_color;
  gsd_state_t        state;
  gsd_state_t        state_next;
  logic              emit;
  gsd_result_t       result;
  logic              advance;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code  <= s_tdata[7:0];
      in_ox    <= s_tdata[17:8];
      in_oy    <= s_tdata[27:18];
      in_start <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= ScaleReset;
      draw_color <= ColorReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegScale:     scale <= cfg_data[ScaleW-1:0];
        RegDrawColor: draw_color <= cfg_data;
        default:      scale <= scale;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  gsd_step u_step (
    .code_byte   (in_code),
    .glyph_start (in_start),
    .origin_x    (in_ox),
    .origin_y    (in_oy),
    .scale       (scale),
    .draw_color  (draw_color),
    .state       (state),
    .state_next  (state_next),
    .emit        (emit),
    .result      (result)
  );

  gsd_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .push     (advance && emit),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== tb/glyph_stroke_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_stroke_decoder_tb
// Checks the stroke decoder against a cycle-free model of its decoding.
// Directed items cover dots, plain and mirrored lines, the end marker, items
// after the end, a glyph start in the middle of a line and extreme scales.
// Random glyphs then run under several scale and colour settings, with random
// gaps on the input side and random stalls on the output side. Every result
// is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module glyph_stroke_decoder_tb;
  import gsd_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;
  localparam int MaxIdle     = 18;
  localparam int PhaseItems  = 225;
  localparam int MaxReports  = 10;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [ColorW-1:0]   cfg_data;

  glyph_stroke_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder state and registers as predicted
  logic              line_open;
  logic [CellW-1:0]  open_cell;
  logic              glyph_done;
  logic [ScaleW-1:0] cur_scale;
  logic [ColorW-1:0] cur_color;

  gsd_result_t expected_rects[$];
  int          mismatch_count;
  int          items_sent;
  int          cycle_count;
  bit          tx_quiet;
  bit          rx_quiet;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic push_rect(input int px, input int py, input int w, input int h);
    gsd_result_t r;
    r.kind   = KindRect;
    r.rect_x = px[PosW-1:0];
    r.rect_y = py[PosW-1:0];
    r.rect_w = w[SizeW-1:0];
    r.rect_h = h[SizeW-1:0];
    r.color  = cur_color;
    expected_rects.push_back(r);
  endtask

  task automatic decode_stroke(input logic [CodeW-1:0] code, input logic start,
                               input logic [OrigW-1:0] ox, input logic [OrigW-1:0] oy);
    gsd_result_t r;
    int s, len, back, cell_pos, bx, by;
    s  = int'(cur_scale);
    bx = int'(ox);
    by = int'(oy);
    if (start) begin
      line_open  = 1'b0;
      open_cell  = '0;
      glyph_done = 1'b0;
    end
    if (glyph_done) return;
    if (code[EndBit]) begin
      line_open  = 1'b0;
      open_cell  = '0;
      glyph_done = 1'b1;
      r      = '0;
      r.kind = KindEnd;
      expected_rects.push_back(r);
      return;
    end
    if (line_open) begin
      len      = int'(code[4:0]) + 1;
      back     = code[MirrBit] ? len : 0;
      cell_pos = int'(open_cell);
      line_open = 1'b0;
      open_cell = '0;
      if (code[VertBit]) begin
        if (code[MirrBit]) cell_pos += int'(VertStep);
        push_rect(bx + (cell_pos % 8) * s, by + (cell_pos / 8 - back) * s, s, len * s);
      end else begin
        if (code[MirrBit]) cell_pos += int'(HorzStep);
        push_rect(bx + (cell_pos % 8 - back) * s, by + (cell_pos / 8) * s, len * s, s);
      end
      return;
    end
    if (code[LineBit]) begin
      line_open = 1'b1;
      open_cell = code[CellW-1:0];
      return;
    end
    push_rect(bx + (int'(code) % 8) * s, by + (int'(code) / 8) * s, s, s);
  endtask

  task automatic report_mismatch(input string what, input gsd_result_t exp_r,
                                 input gsd_result_t got_r);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: %s: expected kind %0d x %0d y %0d w %0d h %0d colour %h",
               $time, what, exp_r.kind, $signed(exp_r.rect_x), $signed(exp_r.rect_y),
               exp_r.rect_w, exp_r.rect_h, exp_r.color);
      $display("%0t: %s: actual   kind %0d x %0d y %0d w %0d h %0d colour %h",
               $time, what, got_r.kind, $signed(got_r.rect_x), $signed(got_r.rect_y),
               got_r.rect_w, got_r.rect_h, got_r.color);
    end
  endtask

  // predict on every accepted byte, then check every accepted result
  always @(posedge clk) begin
    gsd_result_t got_r;
    gsd_result_t exp_r;
    if (rst) begin
      line_open  = 1'b0;
      open_cell  = '0;
      glyph_done = 1'b0;
      cur_scale  = ScaleReset;
      cur_color  = ColorReset;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegScale) cur_scale = cfg_data[ScaleW-1:0];
        else cur_color = cfg_data;
      end
      if (s_tvalid && s_tready)
        decode_stroke(s_tdata[7:0], s_tuser, s_tdata[17:8], s_tdata[27:18]);
      if (m_tvalid && m_tready) begin
        got_r.kind   = m_tuser;
        got_r.rect_x = m_tdata[11:0];
        got_r.rect_y = m_tdata[23:12];
        got_r.rect_w = m_tdata[32:24];
        got_r.rect_h = m_tdata[41:33];
        got_r.color  = m_tdata[57:42];
        if (expected_rects.size() == 0) begin
          report_mismatch("result with none pending", '0, got_r);
        end else begin
          exp_r = expected_rects.pop_front();
          if (got_r.kind !== exp_r.kind || got_r.rect_x !== exp_r.rect_x ||
              got_r.rect_y !== exp_r.rect_y || got_r.rect_w !== exp_r.rect_w ||
              got_r.rect_h !== exp_r.rect_h || got_r.color !== exp_r.color)
            report_mismatch("result mismatch", exp_r, got_r);
        end
      end
    end
  end

  // output side: drop m_tready for a random stall before each item unless rx_quiet is set
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MaxIdle);
      repeat (stall) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_code(input logic [CodeW-1:0] code, input logic start,
                           input logic [OrigW-1:0] ox, input logic [OrigW-1:0] oy);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxIdle);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, oy, ox, code};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ColorW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_dots();
    send_code(8'h00, 1'b1, 10'd0, 10'd0);
    send_code(8'h3F, 1'b0, 10'd1023, 10'd1023);
    send_code(8'h2A, 1'b0, 10'd517, 10'd250);
    drain();
  endtask

  task automatic test_lines();
    send_code(8'h40, 1'b0, 10'd100, 10'd200);
    send_code(8'h1F, 1'b0, 10'd100, 10'd200);
    send_code(8'h7F, 1'b0, 10'd0, 10'd0);
    send_code(8'h7F, 1'b0, 10'd0, 10'd0);
    send_code(8'h47, 1'b0, 10'd1023, 10'd5);
    send_code(8'h20, 1'b0, 10'd1023, 10'd5);
    drain();
  endtask

  task automatic test_end_marker();
    send_code(8'h80, 1'b1, 10'd33, 10'd44);
    send_code(8'h12, 1'b0, 10'd33, 10'd44);
    send_code(8'hFF, 1'b0, 10'd33, 10'd44);
    send_code(8'h41, 1'b1, 10'd33, 10'd44);
    send_code(8'hC0, 1'b0, 10'd33, 10'd44);
    drain();
  endtask

  task automatic test_start_mid_line();
    send_code(8'h45, 1'b1, 10'd300, 10'd600);
    send_code(8'h09, 1'b1, 10'd300, 10'd600);
    send_code(8'h80, 1'b1, 10'd300, 10'd600);
    drain();
  endtask

  task automatic test_scale_extremes();
    write_reg(RegScale, 16'h0000);
    write_reg(RegDrawColor, 16'h0000);
    send_code(8'h09, 1'b1, 10'd512, 10'd512);
    send_code(8'h52, 1'b0, 10'd512, 10'd512);
    send_code(8'h41, 1'b0, 10'd512, 10'd512);
    drain();
    write_reg(RegScale, 16'hFFFF);
    send_code(8'h7F, 1'b1, 10'd0, 10'd0);
    send_code(8'h3F, 1'b0, 10'd0, 10'd0);
    send_code(8'h80, 1'b0, 10'd0, 10'd0);
    drain();
  endtask

  task automatic send_glyph();
    logic [OrigW-1:0] ox, oy;
    bit   first, wander;
    int   strokes, pick;
    tx_quiet = ($urandom_range(0, 4) == 0);
    rx_quiet = ($urandom_range(0, 4) == 0);
    ox      = OrigW'($urandom_range(0, 1023));
    oy      = OrigW'($urandom_range(0, 1023));
    wander  = ($urandom_range(0, 7) == 0);
    strokes = $urandom_range(0, 10);
    first   = 1'b1;
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3))
        send_code(CodeW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  OrigW'($urandom_range(0, 1023)), OrigW'($urandom_range(0, 1023)));
    for (int i = 0; i < strokes; i++) begin
      if (wander) begin
        ox = OrigW'($urandom_range(0, 1023));
        oy = OrigW'($urandom_range(0, 1023));
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_code(CodeW'($urandom_range(0, 63)), first, ox, oy);
      end else begin
        send_code(CodeW'(8'h40 | $urandom_range(0, 63)), first, ox, oy);
        if (pick < 9) send_code(CodeW'($urandom_range(0, 127)), 1'b0, ox, oy);
      end
      first = 1'b0;
    end
    if ($urandom_range(0, 7) != 0) begin
      send_code(CodeW'(8'h80 | $urandom_range(0, 127)), first, ox, oy);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_code(CodeW'($urandom_range(0, 255)), 1'b0, ox, oy);
    end
  endtask

  task automatic test_random();
    logic [ScaleW-1:0] scales[6];
    logic [ColorW-1:0] colours[6];
    int goal;
    scales  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'($urandom_range(2, 7)), 4'($urandom_range(1, 8))};
    colours = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom)};
    foreach (scales[p]) begin
      write_reg(RegScale, {12'($urandom), scales[p]});
      write_reg(RegDrawColor, colours[p]);
      goal = items_sent + PhaseItems;
      while (items_sent < goal) send_glyph();
      drain();
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = RegScale;
    cfg_data       = '0;
    mismatch_count = 0;
    items_sent     = 0;
    tx_quiet       = 1'b0;
    rx_quiet       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_dots();
    test_lines();
    test_end_marker();
    test_start_mid_line();
    test_scale_extremes();
    test_random();

    if (expected_rects.size() != 0) begin
      mismatch_count++;
      $display("%0d results never arrived", expected_rects.size());
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
